// File: hdl/gcpr_pkg.sv
// ----------------------------------------------------------------------------
// gcpr_pkg
// Shared types and constants for the controller poll responder.
// ----------------------------------------------------------------------------
package gcpr_pkg;

  localparam int unsigned SLOT_STORE        = 4;
  localparam int unsigned SLOT_RECORD_BYTES = 8;
  localparam int unsigned FRAME_BYTES       = 3 + SLOT_STORE * SLOT_RECORD_BYTES;
  localparam int unsigned IDX_W             = $clog2(FRAME_BYTES + 1);
  localparam int unsigned SLOT_W            = $clog2(SLOT_STORE);

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_STANDARD = 3'd1;
  localparam logic [2:0] KIND_MOUSE    = 3'd2;
  localparam logic [2:0] KIND_NEGCON   = 3'd3;
  localparam logic [2:0] KIND_AJOY     = 3'd4;
  localparam logic [2:0] KIND_APAD     = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_POLL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] buttons;
    logic [31:0] sticks;   // rx, ry, lx, ly from the high byte down
    logic [15:0] motion;   // mx high, my low
  } slot_t;

endpackage

// File: hdl/gcpr_ram.sv
// ----------------------------------------------------------------------------
// gcpr_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module gcpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 35
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gcpr_frame_gen.sv
// ----------------------------------------------------------------------------
// gcpr_frame_gen
// Works out one response frame byte from its index and the pad slots.
// ----------------------------------------------------------------------------
module gcpr_frame_gen import gcpr_pkg::*; (
  input  logic                        multitap_i,
  input  logic [IDX_W-1:0]            index_i,
  input  slot_t [SLOT_STORE-1:0]      slots_i,
  output logic [7:0]                  byte_o
);

  localparam logic [7:0] ID_STANDARD = 8'h41;
  localparam logic [7:0] ID_MOUSE    = 8'h12;
  localparam logic [7:0] ID_NEGCON   = 8'h23;
  localparam logic [7:0] ID_AJOY     = 8'h53;
  localparam logic [7:0] ID_APAD     = 8'h73;
  localparam logic [7:0] SYNC_BYTE   = 8'h5A;
  localparam logic [7:0] TAP_ID      = 8'h80;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;

  function automatic logic [7:0] kind_id(logic [2:0] kind);
    logic [7:0] id;
    case (kind)
      KIND_MOUSE:  id = ID_MOUSE;
      KIND_NEGCON: id = ID_NEGCON;
      KIND_AJOY:   id = ID_AJOY;
      KIND_APAD:   id = ID_APAD;
      default:     id = ID_STANDARD;
    endcase
    return id;
  endfunction

  function automatic logic [7:0] rec_byte(slot_t s, logic [2:0] pos);
    logic [7:0] b;
    logic       mouse;
    logic       stick;
    mouse = (s.kind == KIND_MOUSE);
    stick = s.kind inside {KIND_NEGCON, KIND_AJOY, KIND_APAD};
    b     = IDLE_BYTE;
    case (pos)
      3'd0: b = kind_id(s.kind);
      3'd1: b = SYNC_BYTE;
      3'd2: b = s.buttons[7:0];
      3'd3: b = s.buttons[15:8];
      3'd4: begin
        if (mouse) b = s.motion[15:8];
        else if (stick) b = s.sticks[31:24];
      end
      3'd5: begin
        if (mouse) b = s.motion[7:0];
        else if (stick) b = s.sticks[23:16];
      end
      3'd6: if (stick) b = s.sticks[15:8];
      3'd7: if (stick) b = s.sticks[7:0];
      default: b = IDLE_BYTE;
    endcase
    return b;
  endfunction

  logic [IDX_W-1:0] tap_off;
  logic [IDX_W-1:0] pad_off;
  slot_t            tap_slot;

  assign tap_off  = index_i - IDX_W'(3);
  assign pad_off  = index_i - IDX_W'(1);
  assign tap_slot = slots_i[tap_off[SLOT_W+2:3]];

  always_comb begin
    if (multitap_i) begin
      case (index_i)
        IDX_W'(0): byte_o = 8'h00;
        IDX_W'(1): byte_o = TAP_ID;
        IDX_W'(2): byte_o = SYNC_BYTE;
        default:   byte_o = rec_byte(tap_slot, tap_off[2:0]);
      endcase
    end else if (slots_i[0].kind == KIND_NONE) begin
      byte_o = IDLE_BYTE;
    end else if (index_i == '0) begin
      byte_o = 8'h00;
    end else begin
      byte_o = rec_byte(slots_i[0], pad_off[2:0]);
    end
  end

endmodule

// File: hdl/game_controller_poll_responder_top.sv
// ----------------------------------------------------------------------------
// game_controller_poll_responder_top
// Controller port poll responder with optional four-slot multitap frame.
// ----------------------------------------------------------------------------
// A start item writes the response frame into the frame RAM one byte a cycle
// through the byte generator, so it is busy until the last byte is written,
// and strobes the first byte in the cycle after. A poll item reads the frame
// RAM: it moves to the read state, where the registered RAM byte is taken
// into the output register; a poll past the frame strobes in the next cycle.
// Results are shown for one cycle on out_strobe_o and cannot be stalled.
// The multitap register is written through the cfg channel, which is always
// ready.
module game_controller_poll_responder_top import gcpr_pkg::*; #(
  parameter int unsigned PAD_SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  slot_i,
  input  logic [2:0]  pad_type_i,
  input  logic [15:0] buttons_i,
  input  logic [7:0]  right_x_i,
  input  logic [7:0]  right_y_i,
  input  logic [7:0]  left_x_i,
  input  logic [7:0]  left_y_i,
  input  logic [7:0]  motion_x_i,
  input  logic [7:0]  motion_y_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_wdata_i,
  output logic        out_strobe_o,
  output logic [7:0]  data_byte_o,
  output logic        is_last_o,
  output logic        past_end_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_READ
  } state_e;

  localparam logic [IDX_W-1:0] LAST_NONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_STD   = IDX_W'(4);
  localparam logic [IDX_W-1:0] LAST_MOUSE = IDX_W'(6);
  localparam logic [IDX_W-1:0] LAST_STICK = IDX_W'(8);
  localparam logic [IDX_W-1:0] LAST_TAP   = IDX_W'(FRAME_BYTES - 1);

  state_e                 state_q, state_d;
  logic                   tap_q, tap_d;
  logic                   mt_en_q, mt_en_d;
  slot_t [SLOT_STORE-1:0] slots_q, slots_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]       last_q, last_d;
  logic                   strobe_q, strobe_d;
  logic [7:0]             data_q, data_d;
  logic                   is_last_q, is_last_d;
  logic                   past_q, past_d;

  logic                   accept;
  logic                   ram_we;
  logic [7:0]             gen_byte;
  logic [7:0]             ram_rdata;
  logic [IDX_W-1:0]       pad_last;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign ram_we      = (state_q == ST_BUILD);

  gcpr_frame_gen u_gen (
    .multitap_i (tap_q),
    .index_i    (idx_q),
    .slots_i    (slots_q),
    .byte_o     (gen_byte)
  );

  gcpr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[$clog2(FRAME_BYTES)-1:0]),
    .wdata_i (gen_byte),
    .raddr_i (rd_idx_q[$clog2(FRAME_BYTES)-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (slots_q[0].kind)
      KIND_NONE:                         pad_last = LAST_NONE;
      KIND_MOUSE:                        pad_last = LAST_MOUSE;
      KIND_NEGCON, KIND_AJOY, KIND_APAD: pad_last = LAST_STICK;
      default:                           pad_last = LAST_STD;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    mt_en_d   = mt_en_q;
    slots_d   = slots_q;
    idx_d     = idx_q;
    rd_idx_d  = rd_idx_q;
    last_d    = last_q;
    strobe_d  = 1'b0;
    data_d    = data_q;
    is_last_d = is_last_q;
    past_d    = past_q;

    if (cfg_valid_i) begin
      mt_en_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_LOAD: begin
              if ({1'b0, slot_i} < 3'(PAD_SLOTS)) begin
                slots_d[slot_i].kind    = pad_type_i;
                slots_d[slot_i].buttons = buttons_i;
                slots_d[slot_i].sticks  = {right_x_i, right_y_i, left_x_i, left_y_i};
                slots_d[slot_i].motion  = {motion_x_i, motion_y_i};
              end
            end
            OP_START: begin
              tap_d   = mt_en_q;
              idx_d   = '0;
              last_d  = mt_en_q ? LAST_TAP : pad_last;
              state_d = ST_BUILD;
            end
            OP_POLL: begin
              if (rd_idx_q > last_q || rd_idx_q >= IDX_W'(FRAME_BYTES)) begin
                strobe_d  = 1'b1;
                data_d    = 8'h00;
                is_last_d = 1'b0;
                past_d    = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BUILD: begin
        if (idx_q == last_q) begin
          strobe_d  = 1'b1;
          data_d    = (!tap_q && slots_q[0].kind == KIND_NONE) ? 8'hFF : 8'h00;
          is_last_d = 1'b0;
          past_d    = 1'b0;
          rd_idx_d  = IDX_W'(1);
          state_d   = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_READ: begin
        strobe_d  = 1'b1;
        data_d    = ram_rdata;
        is_last_d = (rd_idx_q == last_q);
        past_d    = 1'b0;
        rd_idx_d  = rd_idx_q + IDX_W'(1);
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= 1'b0;
      mt_en_q   <= 1'b0;
      for (int s = 0; s < SLOT_STORE; s++) begin
        slots_q[s].kind    <= KIND_NONE;
        slots_q[s].buttons <= 16'hFFFF;
        slots_q[s].sticks  <= 32'h8080_8080;
        slots_q[s].motion  <= 16'h0000;
      end
      idx_q     <= '0;
      rd_idx_q  <= '0;
      last_q    <= '0;
      strobe_q  <= 1'b0;
      data_q    <= 8'h00;
      is_last_q <= 1'b0;
      past_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_q     <= tap_d;
      mt_en_q   <= mt_en_d;
      slots_q   <= slots_d;
      idx_q     <= idx_d;
      rd_idx_q  <= rd_idx_d;
      last_q    <= last_d;
      strobe_q  <= strobe_d;
      data_q    <= data_d;
      is_last_q <= is_last_d;
      past_q    <= past_d;
    end
  end

  assign out_strobe_o = strobe_q;
  assign data_byte_o  = data_q;
  assign is_last_o    = is_last_q;
  assign past_end_o   = past_q;

endmodule
